[hdl/waveform_pulse_integrator_core_defines.svh]
// Assertion macros used by the port-level checker file of the pulse integrator.
`ifndef WAVEFORM_PULSE_INTEGRATOR_CORE_DEFINES_SVH
`define WAVEFORM_PULSE_INTEGRATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define WPI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pulse integrator assertion failed");

// Next-cycle implication, disabled while reset is low.
`define WPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pulse integrator assertion failed");

`endif

[hdl/wpi_pkg.sv]
// Package with widths, constants, register codes and the configuration type.
package wpi_pkg;

    localparam int MAX_SAMPLES = 16384;
    localparam int SAMPLE_BITS = 12;
    localparam int IDX_W       = 14;
    localparam int LEN_W       = 15;
    localparam int LEVEL_W     = 16;
    localparam int GUARD_W     = 10;
    localparam int SUM_W       = 31;
    localparam int AMP_W       = 16;
    localparam int FRAC_BITS   = 4;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [LEN_W-1:0]   LEN_MAX        = LEN_W'(MAX_SAMPLES);
    localparam logic [LEN_W-1:0]   LEN_MIN        = LEN_W'(1);
    localparam logic [LEN_W-1:0]   MIN_WIDTH_EXCL = LEN_W'(2);
    localparam logic [GUARD_W-1:0] GUARD_RST      = GUARD_W'(50);
    localparam logic [LEN_W-1:0]   LENGTH_RST     = LEN_W'(15000);
    localparam logic [SUM_W-1:0]   SUM_MAX        = '1;

    typedef enum logic [2:0] {
        REG_PEDESTAL = 3'd0,
        REG_MAIN     = 3'd1,
        REG_BAND     = 3'd2,
        REG_GUARD    = 3'd3,
        REG_LENGTH   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] pedestal_level;
        logic [LEVEL_W-1:0] main_level;
        logic [LEVEL_W-1:0] band_level;
        logic [GUARD_W-1:0] edge_guard;
        logic [LEN_W-1:0]   waveform_length;
    } t_cfg;

endpackage

[hdl/wpi_channel_if.sv]
// Valid/ready channel interfaces for samples in and pulses out.
interface wpi_sample_if;
    import wpi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   last_sample;

    modport source (output valid, output sample_value, output last_sample, input ready);
    modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface wpi_pulse_if;
    import wpi_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   pulse_start;
    logic [LEN_W-1:0]   pulse_width;
    logic [SUM_W-1:0]   pulse_integral;
    logic [AMP_W-1:0]   pulse_peak;
    logic               main_hit;
    logic               band_hit;

    modport source (output valid, output pulse_start, output pulse_width,
                    output pulse_integral, output pulse_peak, output main_hit,
                    output band_hit, input ready);
    modport sink   (input valid, input pulse_start, input pulse_width,
                    input pulse_integral, input pulse_peak, input main_hit,
                    input band_hit, output ready);
endinterface

[hdl/wpi_apb_regs.sv]
// APB configuration register file of the pulse integrator.
module wpi_apb_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [wpi_pkg::ADDR_W-1:0] paddr,
    input  logic [wpi_pkg::DATA_W-1:0] pwdata,
    output logic [wpi_pkg::DATA_W-1:0] prdata,
    output logic                  pready,
    output wpi_pkg::t_cfg         o_cfg
);
    import wpi_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pedestal_level  <= '0;
            r_cfg.main_level      <= '0;
            r_cfg.band_level      <= '0;
            r_cfg.edge_guard      <= GUARD_RST;
            r_cfg.waveform_length <= LENGTH_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PEDESTAL: r_cfg.pedestal_level  <= pwdata[LEVEL_W-1:0];
                REG_MAIN:     r_cfg.main_level      <= pwdata[LEVEL_W-1:0];
                REG_BAND:     r_cfg.band_level      <= pwdata[LEVEL_W-1:0];
                REG_GUARD:    r_cfg.edge_guard      <= pwdata[GUARD_W-1:0];
                REG_LENGTH:   r_cfg.waveform_length <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PEDESTAL: prdata = DATA_W'(r_cfg.pedestal_level);
            REG_MAIN:     prdata = DATA_W'(r_cfg.main_level);
            REG_BAND:     prdata = DATA_W'(r_cfg.band_level);
            REG_GUARD:    prdata = DATA_W'(r_cfg.edge_guard);
            REG_LENGTH:   prdata = DATA_W'(r_cfg.waveform_length);
            default:      prdata = '0;
        endcase
    end

endmodule

[hdl/waveform_pulse_integrator_core.sv]
// Top level: threshold pulse finder with charge integration per waveform.
//
//   channel    dir   handshake        payload
//   i_sample   in    valid/ready      sample_value, last_sample
//   o_pulse    out   valid/ready      start, width, integral, peak, main_hit, band_hit
//   apb        in    psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One item per cycle unless o_pulse stalls; a sample passes the input and result registers.
// An input register feeds one add/compare pass that updates the run and the result register.
// Reset clears the run state, sample index, and both valid flags; registers take defaults.
// A stalled pulse output holds the pass; the input register still fills once.
module waveform_pulse_integrator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    wpi_sample_if.sink                 i_sample,
    wpi_pulse_if.source                o_pulse,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wpi_pkg::ADDR_W-1:0] paddr,
    input  logic [wpi_pkg::DATA_W-1:0] pwdata,
    output logic [wpi_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import wpi_pkg::*;

    t_cfg cfg;

    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic                   r_in_last;

    logic [IDX_W-1:0] r_sample_index, n_sample_index;
    logic             r_in_run,       n_in_run;
    logic [IDX_W-1:0] r_run_start,    n_run_start;
    logic [SUM_W-1:0] r_run_sum,      n_run_sum;
    logic [AMP_W-1:0] r_run_peak,     n_run_peak;
    logic             r_main_mark,    n_main_mark;
    logic             r_band_mark,    n_band_mark;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_start;
    logic [LEN_W-1:0] r_out_width;
    logic [SUM_W-1:0] r_out_integral;
    logic [AMP_W-1:0] r_out_peak;
    logic             r_out_main;
    logic             r_out_band;

    logic             advance;
    logic             in_ready;
    logic [LEN_W-1:0] len_eff;
    logic [AMP_W:0]   amp_wide;
    logic             amp_pos;
    logic [AMP_W-1:0] amp;
    logic             in_win;
    logic [IDX_W-1:0] base_start;
    logic [SUM_W-1:0] base_sum;
    logic [AMP_W-1:0] base_peak;
    logic             base_main;
    logic             base_band;
    logic [SUM_W:0]   sum_ext;
    logic [LEN_W-1:0] run_width;
    logic             emit;
    logic             wave_end;

    wpi_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance        = r_in_valid && (!r_out_valid || o_pulse.ready);
    assign in_ready       = !r_in_valid || advance;
    assign i_sample.ready = in_ready;

    always_comb begin
        if (cfg.waveform_length == '0) begin
            len_eff = LEN_MIN;
        end else if (cfg.waveform_length > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = cfg.waveform_length;
        end
    end

    assign amp_wide = {1'b0, cfg.pedestal_level}
                    - {1'b0, AMP_W'({r_in_sample, {FRAC_BITS{1'b0}}})};
    assign amp_pos  = !amp_wide[AMP_W] && (amp_wide != '0);
    assign amp      = amp_wide[AMP_W-1:0];
    assign in_win   = (LEN_W'(r_sample_index) >= LEN_W'(cfg.edge_guard))
                   && ((LEN_W'(r_sample_index) + LEN_W'(cfg.edge_guard)) < len_eff);

    assign base_start = r_in_run ? r_run_start : r_sample_index;
    assign base_sum   = r_in_run ? r_run_sum   : '0;
    assign base_peak  = r_in_run ? r_run_peak  : '0;
    assign base_main  = r_in_run && r_main_mark;
    assign base_band  = r_in_run && r_band_mark;
    assign sum_ext    = {1'b0, base_sum} + (SUM_W+1)'(amp);

    assign run_width = LEN_W'(r_sample_index - r_run_start);
    assign emit      = !amp_pos && r_in_run && (run_width > MIN_WIDTH_EXCL)
                    && (r_run_start != '0) && (r_main_mark || r_band_mark);
    assign wave_end  = r_in_last || ((LEN_W'(r_sample_index) + LEN_W'(1)) >= len_eff);

    always_comb begin
        n_sample_index = r_sample_index + IDX_W'(1);
        n_in_run       = r_in_run;
        n_run_start    = r_run_start;
        n_run_sum      = r_run_sum;
        n_run_peak     = r_run_peak;
        n_main_mark    = r_main_mark;
        n_band_mark    = r_band_mark;
        if (amp_pos) begin
            n_in_run    = 1'b1;
            n_run_start = base_start;
            n_run_sum   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            n_run_peak  = (amp > base_peak) ? amp : base_peak;
            n_main_mark = base_main || (in_win && (amp > cfg.main_level));
            n_band_mark = base_band || (in_win && (amp > cfg.band_level)
                                               && (amp < cfg.main_level));
        end else if (r_in_run) begin
            n_in_run    = 1'b0;
            n_run_start = '0;
            n_run_sum   = '0;
            n_run_peak  = '0;
            n_main_mark = 1'b0;
            n_band_mark = 1'b0;
        end
        if (wave_end) begin
            n_sample_index = '0;
            n_in_run       = 1'b0;
            n_run_start    = '0;
            n_run_sum      = '0;
            n_run_peak     = '0;
            n_main_mark    = 1'b0;
            n_band_mark    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_sample_index <= '0;
            r_in_run       <= 1'b0;
            r_run_start    <= '0;
            r_run_sum      <= '0;
            r_run_peak     <= '0;
            r_main_mark    <= 1'b0;
            r_band_mark    <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (advance) begin
                r_out_valid    <= emit;
                r_sample_index <= n_sample_index;
                r_in_run       <= n_in_run;
                r_run_start    <= n_run_start;
                r_run_sum      <= n_run_sum;
                r_run_peak     <= n_run_peak;
                r_main_mark    <= n_main_mark;
                r_band_mark    <= n_band_mark;
            end else if (o_pulse.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in_sample <= i_sample.sample_value;
            r_in_last   <= i_sample.last_sample;
        end
        if (advance && emit) begin
            r_out_start    <= r_run_start;
            r_out_width    <= run_width;
            r_out_integral <= r_run_sum;
            r_out_peak     <= r_run_peak;
            r_out_main     <= r_main_mark;
            r_out_band     <= r_band_mark;
        end
    end

    assign o_pulse.valid          = r_out_valid;
    assign o_pulse.pulse_start    = r_out_start;
    assign o_pulse.pulse_width    = r_out_width;
    assign o_pulse.pulse_integral = r_out_integral;
    assign o_pulse.pulse_peak     = r_out_peak;
    assign o_pulse.main_hit       = r_out_main;
    assign o_pulse.band_hit       = r_out_band;

endmodule

[hdl/wpi_checker.sv]
// Port-level checker of the pulse integrator and its bind to the top level.
`include "waveform_pulse_integrator_core_defines.svh"

module wpi_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [wpi_pkg::IDX_W-1:0]   i_out_start,
    input logic [wpi_pkg::LEN_W-1:0]   i_out_width,
    input logic [wpi_pkg::SUM_W-1:0]   i_out_integral,
    input logic [wpi_pkg::AMP_W-1:0]   i_out_peak,
    input logic                        i_out_main,
    input logic                        i_out_band
);
    import wpi_pkg::*;

    logic [IDX_W+LEN_W+SUM_W+AMP_W+1:0] out_payload;
    logic                               out_sane;

    assign out_payload = {i_out_start, i_out_width, i_out_integral, i_out_peak,
                          i_out_main, i_out_band};
    assign out_sane    = (i_out_main || i_out_band) && (i_out_width > MIN_WIDTH_EXCL)
                      && (i_out_start != '0) && (i_out_peak != '0)
                      && (i_out_integral >= SUM_W'(i_out_peak));

    `WPI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `WPI_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(out_payload))
    `WPI_ASSERT_IMPL(a_pulse_sane, i_clk, i_rst_n, i_out_valid, out_sane)
    `WPI_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind waveform_pulse_integrator_core wpi_checker u_wpi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_sample.ready),
    .i_out_valid    (o_pulse.valid),
    .i_out_ready    (o_pulse.ready),
    .i_out_start    (o_pulse.pulse_start),
    .i_out_width    (o_pulse.pulse_width),
    .i_out_integral (o_pulse.pulse_integral),
    .i_out_peak     (o_pulse.pulse_peak),
    .i_out_main     (o_pulse.main_hit),
    .i_out_band     (o_pulse.band_hit)
);

[sim/wpi_pulse_checker.sv]
// Checker for the pulse integrator: mirrors register writes, predicts pulses and compares them.
module wpi_pulse_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    wpi_sample_if                      sample_ch,
    wpi_pulse_if                       pulse_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wpi_pkg::ADDR_W-1:0] paddr,
    input  logic [wpi_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    output int                         o_fail_count,
    output int                         o_pending
);
    import wpi_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] start;
        logic [LEN_W-1:0] width;
        logic [SUM_W-1:0] integral;
        logic [AMP_W-1:0] peak;
        logic             main_hit;
        logic             band_hit;
    } t_pulse;

    t_cfg             cfg_q;
    logic [IDX_W-1:0] index_q;
    logic             in_run_q;
    logic [IDX_W-1:0] start_q;
    logic [SUM_W-1:0] sum_q;
    logic [AMP_W-1:0] peak_q;
    logic             main_q;
    logic             band_q;
    t_pulse           pulses_due[$];
    int               fail_count = 0;

    function automatic void clear_run();
        in_run_q = 1'b0;
        start_q  = '0;
        sum_q    = '0;
        peak_q   = '0;
        main_q   = 1'b0;
        band_q   = 1'b0;
    endfunction

    task automatic integrate_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
        int     len;
        int     idx;
        int     amp;
        int     width;
        bit     in_win;
        t_pulse p;
        len = int'(cfg_q.waveform_length);
        if (len == 0) len = 1;
        if (len > MAX_SAMPLES) len = MAX_SAMPLES;
        idx    = int'(index_q);
        amp    = int'(cfg_q.pedestal_level) - int'(s) * (1 << FRAC_BITS);
        in_win = idx >= int'(cfg_q.edge_guard) && idx + int'(cfg_q.edge_guard) < len;
        if (amp > 0) begin
            if (!in_run_q) begin
                clear_run();
                in_run_q = 1'b1;
                start_q  = index_q;
            end
            if (longint'(sum_q) + longint'(amp) > longint'(SUM_MAX)) begin
                sum_q = SUM_MAX;
            end else begin
                sum_q = sum_q + SUM_W'(amp);
            end
            if (amp > int'(peak_q)) peak_q = AMP_W'(amp);
            if (in_win) begin
                if (amp > int'(cfg_q.main_level)) begin
                    main_q = 1'b1;
                end else if (amp > int'(cfg_q.band_level) && amp < int'(cfg_q.main_level)) begin
                    band_q = 1'b1;
                end
            end
        end else if (in_run_q) begin
            width = idx - int'(start_q);
            if (width > int'(MIN_WIDTH_EXCL) && start_q != '0 && (main_q || band_q)) begin
                p.start    = start_q;
                p.width    = LEN_W'(width);
                p.integral = sum_q;
                p.peak     = peak_q;
                p.main_hit = main_q;
                p.band_hit = band_q;
                pulses_due = {pulses_due, p};
            end
            clear_run();
        end
        if (last || idx + 1 >= len) begin
            index_q = '0;
            clear_run();
        end else begin
            index_q = IDX_W'(idx + 1);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_pulse();
        t_pulse want;
        if (pulses_due.size() == 0) begin
            $error("pulse_start expected none actual %0d", pulse_ch.pulse_start);
            fail_count++;
        end else begin
            want = pulses_due.pop_front();
            compare_field("pulse_start", 32'(want.start), 32'(pulse_ch.pulse_start));
            compare_field("pulse_width", 32'(want.width), 32'(pulse_ch.pulse_width));
            compare_field("pulse_integral", 32'(want.integral), 32'(pulse_ch.pulse_integral));
            compare_field("pulse_peak", 32'(want.peak), 32'(pulse_ch.pulse_peak));
            compare_field("main_hit", 32'(want.main_hit), 32'(pulse_ch.main_hit));
            compare_field("band_hit", 32'(want.band_hit), 32'(pulse_ch.band_hit));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q.pedestal_level  = '0;
            cfg_q.main_level      = '0;
            cfg_q.band_level      = '0;
            cfg_q.edge_guard      = GUARD_RST;
            cfg_q.waveform_length = LENGTH_RST;
            index_q               = '0;
            clear_run();
            pulses_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_PEDESTAL: cfg_q.pedestal_level  = pwdata[LEVEL_W-1:0];
                    REG_MAIN:     cfg_q.main_level      = pwdata[LEVEL_W-1:0];
                    REG_BAND:     cfg_q.band_level      = pwdata[LEVEL_W-1:0];
                    REG_GUARD:    cfg_q.edge_guard      = pwdata[GUARD_W-1:0];
                    REG_LENGTH:   cfg_q.waveform_length = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready) begin
                integrate_sample(sample_ch.sample_value, sample_ch.last_sample);
            end
            if (pulse_ch.valid && pulse_ch.ready) begin
                check_pulse();
            end
        end
        o_pending    <= pulses_due.size();
        o_fail_count <= fail_count;
    end

endmodule

[sim/tb_waveform_pulse_integrator_core.sv]
// Testbench top for the pulse integrator: clock, reset, stimulus, output stalls and verdict.
module tb_waveform_pulse_integrator_core;
    import wpi_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 8;
    localparam int SEND_CAP     = 300;
    localparam int MAX_CODE     = (1 << SAMPLE_BITS) - 1;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent  = 0;
    bit steady      = 1'b0;

    logic [LEVEL_W-1:0] ped_lvl;
    logic [LEVEL_W-1:0] main_lvl;
    logic [LEVEL_W-1:0] band_lvl;
    logic [GUARD_W-1:0] guard_len;
    logic [LEN_W-1:0]   wave_len;
    int                 eff_len;

    int directed_codes[24] = '{100, 100, 100, 4095, 1500, 1500, 1500, 2049,
                               1900, 1900, 4095, 0, 1950, 1950, 2049,
                               1900, 1950, 1900, 2049, 1000, 1000, 1000, 1000, 1000};

    wpi_sample_if sample_ch ();
    wpi_pulse_if  pulse_ch ();

    waveform_pulse_integrator_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_pulse  (pulse_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wpi_pulse_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .sample_ch    (sample_ch),
        .pulse_ch     (pulse_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pulse_ch.ready <= 1'b0;
        end else begin
            pulse_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
        end
    end

    task automatic send_sample(input int code, input logic last);
        while (!steady && $urandom_range(0, 99) < 19) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= SAMPLE_BITS'(code);
        sample_ch.last_sample  <= last;
        do @(posedge i_clk); while (!sample_ch.ready);
        items_sent++;
    endtask

    task automatic drain_pulses();
        sample_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings();
        write_reg(REG_PEDESTAL, DATA_W'(ped_lvl));
        write_reg(REG_MAIN, DATA_W'(main_lvl));
        write_reg(REG_BAND, DATA_W'(band_lvl));
        write_reg(REG_GUARD, DATA_W'(guard_len));
        write_reg(REG_LENGTH, DATA_W'(wave_len));
        eff_len = int'(wave_len);
        if (eff_len == 0) eff_len = 1;
        if (eff_len > MAX_SAMPLES) eff_len = MAX_SAMPLES;
    endtask

    task automatic pick_settings(input int phase);
        ped_lvl   = LEVEL_W'($urandom_range(4096, 65535));
        main_lvl  = LEVEL_W'($urandom_range(0, int'(ped_lvl)));
        band_lvl  = LEVEL_W'($urandom_range(0, int'(main_lvl)));
        guard_len = GUARD_W'($urandom_range(0, 6));
        wave_len  = LEN_W'($urandom_range(8, SEND_CAP));
        case (phase)
            0: begin
                ped_lvl   = '1;
                main_lvl  = '1;
                band_lvl  = '0;
                guard_len = '0;
                wave_len  = LEN_MAX;
            end
            1: begin
                ped_lvl   = '0;
                main_lvl  = '0;
                band_lvl  = '1;
                guard_len = '1;
                wave_len  = '0;
            end
            2: begin
                main_lvl  = '0;
                band_lvl  = '1;
                guard_len = '0;
                wave_len  = '1;
            end
            3: begin
                main_lvl  = '1;
                band_lvl  = '0;
                guard_len = '1;
                wave_len  = LEN_MAX;
            end
            4: begin
                guard_len = '0;
                wave_len  = LEN_MIN;
            end
            default: begin
                if ($urandom_range(0, 4) == 0) band_lvl = LEVEL_W'($urandom_range(0, 65535));
                if ($urandom_range(0, 9) == 0) wave_len = LEN_W'($urandom_range(0, 3));
            end
        endcase
    endtask

    task automatic send_noise();
        int count;
        count = $urandom_range(1, 20);
        repeat (count) send_sample($urandom_range(0, MAX_CODE), $urandom_range(0, 9) == 0);
    endtask

    task automatic send_waveform();
        int ped;
        int n_cap;
        int n;
        int base_code;
        int top_code;
        int peak_code;
        int target;
        int pulse_left;
        int peak_at;
        int code;
        logic last;
        ped        = int'(ped_lvl);
        n_cap      = (eff_len > SEND_CAP) ? SEND_CAP : eff_len;
        n          = ($urandom_range(0, 1) == 0) ? n_cap : $urandom_range(1, n_cap);
        if (n > TARGET_ITEMS - items_sent) n = TARGET_ITEMS - items_sent;
        base_code  = (ped + 15) >> FRAC_BITS;
        top_code   = (base_code - 1 > MAX_CODE) ? MAX_CODE : base_code - 1;
        pulse_left = 0;
        peak_at    = 0;
        peak_code  = 0;
        for (int i = 0; i < n; i++) begin
            if (pulse_left == 0 && top_code >= 0 && $urandom_range(0, 99) < 10) begin
                pulse_left = $urandom_range(1, 10);
                peak_at    = $urandom_range(1, pulse_left);
                case ($urandom_range(0, 2))
                    0:       target = $urandom_range(int'(main_lvl), ped);
                    1:       target = $urandom_range(int'(band_lvl), int'(main_lvl));
                    default: target = $urandom_range(1, ped);
                endcase
                if (target > ped) target = ped;
                if (target < 1) target = 1;
                peak_code = (ped - target) >> FRAC_BITS;
                if (peak_code > top_code) peak_code = top_code;
            end
            if (pulse_left > 0) begin
                code = (pulse_left == peak_at) ? peak_code : $urandom_range(peak_code, top_code);
                pulse_left--;
            end else begin
                code = base_code + $urandom_range(0, 3);
                if (code > MAX_CODE) code = MAX_CODE;
            end
            last = (i == n - 1) && (n < eff_len || $urandom_range(0, 1) == 1);
            send_sample(code, last);
        end
    endtask

    initial begin
        int phase;
        int budget;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        sample_ch.last_sample  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // leading edge, equal to main, short run, main and band pulses, trailing edge
        ped_lvl   = LEVEL_W'(32776);
        main_lvl  = LEVEL_W'(8776);
        band_lvl  = LEVEL_W'(1000);
        guard_len = GUARD_W'(2);
        wave_len  = LEN_W'(24);
        apply_settings();
        for (int i = 0; i < 24; i++) send_sample(directed_codes[i], i == 23);

        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            drain_pulses();
            pick_settings(phase);
            apply_settings();
            steady <= (phase == 2);
            budget = items_sent + $urandom_range(60, 140);
            while (items_sent < budget && items_sent < TARGET_ITEMS) begin
                if ($urandom_range(0, 99) < 15) send_noise();
                else send_waveform();
                if (phase >= 5 && $urandom_range(0, 9) == 0) drain_pulses();
            end
            phase++;
        end
        steady <= 1'b0;

        drain_pulses();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
